// ----- rtl/core/sdoc_pkg.sv -----
package sdoc_pkg;

  typedef enum logic [1:0] {
    FUNC_START_WR = 2'd0,
    FUNC_START_RD = 2'd1,
    FUNC_RX_FRAME = 2'd2,
    FUNC_TICK     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_WR_DONE = 2'd1,
    KIND_RD_DONE = 2'd2,
    KIND_FAIL    = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_NODE_ID       = 2'd0;
  localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [10:0] ID_TX_BASE = 11'h600;
  localparam logic [10:0] ID_RX_BASE = 11'h580;

  localparam logic [7:0] CMD_WRITE     = 8'h22;
  localparam logic [7:0] CMD_READ      = 8'h40;
  localparam logic [7:0] CMD_WRITE_ACK = 8'h60;
  localparam logic [7:0] CMD_READ_ACK4 = 8'h43;
  localparam logic [7:0] CMD_READ_ACK3 = 8'h47;
  localparam logic [7:0] CMD_READ_ACK2 = 8'h4B;
  localparam logic [7:0] CMD_READ_ACK1 = 8'h4F;

  typedef struct packed {
    logic [6:0] node_id;
    logic [3:0] max_attempts;
    logic [7:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    func_t        func;
    logic [15:0]  obj_index;
    logic [7:0]   obj_subindex;
    logic [31:0]  write_data;
    logic [10:0]  frame_id;
    logic [31:0]  frame_low;
    logic [31:0]  frame_high;
  } item_t;

  typedef struct packed {
    logic         busy;
    logic         is_read;
    logic [15:0]  obj_index;
    logic [7:0]   obj_subindex;
    logic [31:0]  data;
    logic [3:0]   attempts;
    logic [7:0]   waits;
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [10:0]  tx_id;
    logic [31:0]  tx_low;
    logic [31:0]  tx_high;
    logic [31:0]  read_value;
  } result_t;

endpackage

// ----- rtl/core/sdoc_step.sv -----
module sdoc_step
  import sdoc_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res,
  output logic    res_vld
);

  logic [3:0]  lim_att;
  logic [7:0]  lim_tick;
  logic [7:0]  wait_inc;
  logic [7:0]  rx_cmd;
  logic        cmd_ok;
  logic        obj_ok;
  logic        id_ok;
  logic        do_send;
  logic        do_retry;

  // zero limits behave as one
  assign lim_att  = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
  assign lim_tick = (cfg.timeout_ticks == 8'd0) ? 8'd1 : cfg.timeout_ticks;
  assign wait_inc = st.waits + 8'd1;

  assign rx_cmd = item.frame_low[7:0];
  assign obj_ok = (item.frame_low[23:8] == st.obj_index) &&
                  (item.frame_low[31:24] == st.obj_subindex);
  assign id_ok  = (item.frame_id == (ID_RX_BASE + {4'd0, cfg.node_id}));
  assign cmd_ok = st.is_read ?
                  ((rx_cmd == CMD_READ_ACK4) || (rx_cmd == CMD_READ_ACK3) ||
                   (rx_cmd == CMD_READ_ACK2) || (rx_cmd == CMD_READ_ACK1)) :
                  (rx_cmd == CMD_WRITE_ACK);

  always_comb begin
    st_nxt   = st;
    res      = '0;
    res_vld  = 1'b0;
    do_send  = 1'b0;
    do_retry = 1'b0;

    unique case (item.func) inside
      FUNC_START_WR, FUNC_START_RD: begin
        // a start while busy simply replaces the running transfer
        st_nxt.busy         = 1'b1;
        st_nxt.is_read      = (item.func == FUNC_START_RD);
        st_nxt.obj_index    = item.obj_index;
        st_nxt.obj_subindex = item.obj_subindex;
        st_nxt.data         = (item.func == FUNC_START_RD) ? 32'd0 : item.write_data;
        st_nxt.attempts     = 4'd1;
        do_send             = 1'b1;
      end
      FUNC_TICK: begin
        if (st.busy) begin
          st_nxt.waits = wait_inc;
          if (wait_inc >= lim_tick) begin
            do_retry = 1'b1;
          end
        end
      end
      FUNC_RX_FRAME: begin
        if (st.busy) begin
          if (id_ok && cmd_ok && obj_ok) begin
            st_nxt.busy  = 1'b0;
            st_nxt.waits = 8'd0;
            res_vld      = 1'b1;
            if (st.is_read) begin
              res.kind       = KIND_RD_DONE;
              res.read_value = item.frame_high;
            end else begin
              res.kind = KIND_WR_DONE;
            end
          end else begin
            do_retry = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_retry) begin
      if (st.attempts < lim_att) begin
        st_nxt.attempts = st.attempts + 4'd1;
        do_send         = 1'b1;
      end else begin
        st_nxt.busy  = 1'b0;
        st_nxt.waits = 8'd0;
        res_vld      = 1'b1;
        res.kind     = KIND_FAIL;
      end
    end

    if (do_send) begin
      st_nxt.waits = 8'd0;
      res_vld      = 1'b1;
      res.kind     = KIND_SEND;
      res.tx_id    = ID_TX_BASE + {4'd0, cfg.node_id};
      res.tx_low   = {st_nxt.obj_subindex, st_nxt.obj_index,
                      (st_nxt.is_read ? CMD_READ : CMD_WRITE)};
      res.tx_high  = st_nxt.is_read ? 32'd0 : st_nxt.data;
    end
  end

endmodule

// ----- rtl/core/sdo_expedited_client.sv -----
// an accepted input beat waits in the input register until the result register can take its result
// throughput: one input beat per cycle while the result side does not stall; the transfer state updates in one pass
// an input register and a result register separate the two channels
// synchronous active-low reset: idle, no transfer, node 1, 5 attempts, 5 ticks
module sdo_expedited_client
  import sdoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_obj_index,
  input  logic [7:0]  in_obj_subindex,
  input  logic [31:0] in_write_data,
  input  logic [10:0] in_frame_id,
  input  logic [31:0] in_frame_low,
  input  logic [31:0] in_frame_high,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [10:0] out_tx_id,
  output logic [31:0] out_tx_low,
  output logic [31:0] out_tx_high,
  output logic [31:0] out_read_value
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    stg_vld_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  logic    res_vld;
  result_t out_r;
  logic    out_vld_r;
  logic    adv;

  assign adv      = stg_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !stg_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id       <= 7'd1;
      cfg_r.max_attempts  <= 4'd5;
      cfg_r.timeout_ticks <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:       cfg_r.node_id       <= cfg_wdata[6:0];
        CFG_MAX_ATTEMPTS:  cfg_r.max_attempts  <= cfg_wdata[3:0];
        CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.func         <= func_t'(in_func);
      item_r.obj_index    <= in_obj_index;
      item_r.obj_subindex <= in_obj_subindex;
      item_r.write_data   <= in_write_data;
      item_r.frame_id     <= in_frame_id;
      item_r.frame_low    <= in_frame_low;
      item_r.frame_high   <= in_frame_high;
    end
  end

  sdoc_step u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .item    (item_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt),
    .res_vld (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_kind       = out_r.kind;
  assign out_tx_id      = out_r.tx_id;
  assign out_tx_low     = out_r.tx_low;
  assign out_tx_high    = out_r.tx_high;
  assign out_read_value = out_r.read_value;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sdoc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_NODE_ID;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_TICK;
  logic [15:0] in_obj_index = 16'd0;
  logic [7:0]  in_obj_subindex = 8'd0;
  logic [31:0] in_write_data = 32'd0;
  logic [10:0] in_frame_id = 11'd0;
  logic [31:0] in_frame_low = 32'd0;
  logic [31:0] in_frame_high = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [10:0] out_tx_id;
  logic [31:0] out_tx_low;
  logic [31:0] out_tx_high;
  logic [31:0] out_read_value;

  sdo_expedited_client DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_obj_index   (in_obj_index),
    .in_obj_subindex(in_obj_subindex),
    .in_write_data  (in_write_data),
    .in_frame_id    (in_frame_id),
    .in_frame_low   (in_frame_low),
    .in_frame_high  (in_frame_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_tx_id      (out_tx_id),
    .out_tx_low     (out_tx_low),
    .out_tx_high    (out_tx_high),
    .out_read_value (out_read_value)
  );

  always #4 clk = ~clk;

  // client model state and its copy of the registers
  logic        xfer_busy = 1'b0;
  logic        xfer_read = 1'b0;
  logic [15:0] xfer_index = 16'd0;
  logic [7:0]  xfer_sub = 8'd0;
  logic [31:0] xfer_data = 32'd0;
  logic [3:0]  xfer_tries = 4'd0;
  logic [7:0]  xfer_ticks = 8'd0;
  logic [6:0]  node_id_r = 7'd1;
  logic [3:0]  max_tries_r = 4'd5;
  logic [7:0]  tmo_ticks_r = 8'd5;

  result_t sdo_events_q[$];
  result_t want;
  int      mismatches = 0;
  int      beats_sent = 0;
  int      beats_seen = 0;
  int      kind_seen[4] = '{0, 0, 0, 0};
  int      phases_run = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  function automatic logic [31:0] sdo_low(input logic [7:0] cmd, input logic [15:0] idx,
                                          input logic [7:0] sub);
    return {sub, idx, cmd};
  endfunction

  function automatic logic [10:0] rx_id();
    return ID_RX_BASE + {4'd0, node_id_r};
  endfunction

  function automatic void request_frame(output result_t r);
    r            = '0;
    r.kind       = KIND_SEND;
    r.tx_id      = ID_TX_BASE + {4'd0, node_id_r};
    r.tx_low     = sdo_low(xfer_read ? CMD_READ : CMD_WRITE, xfer_index, xfer_sub);
    r.tx_high    = xfer_read ? 32'd0 : xfer_data;
    xfer_ticks   = 8'd0;
  endfunction

  function automatic void resend_or_fail(output result_t r);
    logic [3:0] lim;
    lim = (max_tries_r == 4'd0) ? 4'd1 : max_tries_r;
    if (xfer_tries < lim) begin
      xfer_tries = xfer_tries + 4'd1;
      request_frame(r);
    end else begin
      xfer_busy  = 1'b0;
      xfer_ticks = 8'd0;
      r          = '0;
      r.kind     = KIND_FAIL;
    end
  endfunction

  function automatic bit sdo_client_step(input func_t f, input logic [15:0] idx,
                                         input logic [7:0] sub, input logic [31:0] wd,
                                         input logic [10:0] fid, input logic [31:0] lo,
                                         input logic [31:0] hi, output result_t r);
    logic [7:0] cmd;
    logic [7:0] lim;
    bit         ack_ok;
    r = '0;
    if (f == FUNC_START_WR || f == FUNC_START_RD) begin
      xfer_busy  = 1'b1;
      xfer_read  = (f == FUNC_START_RD);
      xfer_index = idx;
      xfer_sub   = sub;
      xfer_data  = xfer_read ? 32'd0 : wd;
      xfer_tries = 4'd1;
      request_frame(r);
      return 1'b1;
    end
    if (!xfer_busy) return 1'b0;
    if (f == FUNC_TICK) begin
      lim = (tmo_ticks_r == 8'd0) ? 8'd1 : tmo_ticks_r;
      xfer_ticks = xfer_ticks + 8'd1;
      if (xfer_ticks >= lim) begin
        resend_or_fail(r);
        return 1'b1;
      end
      return 1'b0;
    end
    cmd = lo[7:0];
    if (xfer_read)
      ack_ok = (cmd == CMD_READ_ACK4) || (cmd == CMD_READ_ACK3) ||
               (cmd == CMD_READ_ACK2) || (cmd == CMD_READ_ACK1);
    else
      ack_ok = (cmd == CMD_WRITE_ACK);
    if (fid == rx_id() && ack_ok && lo[23:8] == xfer_index && lo[31:24] == xfer_sub) begin
      xfer_busy  = 1'b0;
      xfer_ticks = 8'd0;
      if (xfer_read) begin
        r.kind       = KIND_RD_DONE;
        r.read_value = hi;
      end else begin
        r.kind = KIND_WR_DONE;
      end
      return 1'b1;
    end
    resend_or_fail(r);
    return 1'b1;
  endfunction

  // one input beat; returns at the edge where it was accepted
  task automatic send_beat(input func_t f, input logic [15:0] idx, input logic [7:0] sub,
                           input logic [31:0] wd, input logic [10:0] fid,
                           input logic [31:0] lo, input logic [31:0] hi);
    result_t r;
    bit      has;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_obj_index    <= idx;
    in_obj_subindex <= sub;
    in_write_data   <= wd;
    in_frame_id     <= fid;
    in_frame_low    <= lo;
    in_frame_high   <= hi;
    do @(posedge clk); while (!in_ready);
    has = sdo_client_step(f, idx, sub, wd, fid, lo, hi, r);
    if (has) sdo_events_q.push_back(r);
    beats_sent++;
  endtask

  task automatic start_xfer(input bit rd, input logic [15:0] idx, input logic [7:0] sub,
                            input logic [31:0] wd);
    send_beat(rd ? FUNC_START_RD : FUNC_START_WR, idx, sub, wd, 11'($urandom),
              $urandom, $urandom);
  endtask

  task automatic rx_frame(input logic [10:0] fid, input logic [31:0] lo, input logic [31:0] hi);
    send_beat(FUNC_RX_FRAME, 16'($urandom), 8'($urandom), $urandom, fid, lo, hi);
  endtask

  task automatic tick();
    send_beat(FUNC_TICK, 16'($urandom), 8'($urandom), $urandom, 11'($urandom),
              $urandom, $urandom);
  endtask

  // let everything in flight come out so the registers can change safely
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sdo_events_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_regs(input logic [6:0] node, input logic [3:0] tries,
                          input logic [7:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NODE_ID;
    cfg_wdata <= {1'b0, node};
    @(negedge clk);
    cfg_index <= CFG_MAX_ATTEMPTS;
    cfg_wdata <= {4'd0, tries};
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_we      <= 1'b0;
    node_id_r   = node;
    max_tries_r = tries;
    tmo_ticks_r = tmo;
    phases_run++;
  endtask

  // reset registers: node 1, 5 attempts, 5 ticks
  task automatic test_directed();
    start_xfer(1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    rx_frame(rx_id(), sdo_low(CMD_WRITE_ACK, 16'hFFFF, 8'hFF), 32'hFFFF_FFFF);
    // idle: tick and frame are dropped
    tick();
    rx_frame(rx_id(), sdo_low(CMD_WRITE_ACK, 16'hFFFF, 8'hFF), 32'd0);
    start_xfer(1'b1, 16'h0000, 8'h00, 32'hFFFF_FFFF);
    rx_frame(rx_id(), sdo_low(8'h80, 16'h0000, 8'h00), 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK4, 16'h0000, 8'h00), 32'h8000_0001);
    start_xfer(1'b1, 16'h1234, 8'h56, 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_WRITE_ACK, 16'h1234, 8'h56), 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK3, 16'h1234, 8'h56), 32'hFFFF_FFFF);
    start_xfer(1'b1, 16'hA5A5, 8'h5A, 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK2, 16'hA5A5, 8'h5B), 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK2, 16'hA5A5, 8'h5A), 32'h0000_0001);
    // a new start abandons the running write
    start_xfer(1'b0, 16'h1000, 8'h01, 32'h0000_0000);
    start_xfer(1'b1, 16'h2000, 8'h02, 32'h7FFF_FFFF);
    rx_frame(rx_id(), sdo_low(CMD_WRITE_ACK, 16'h1000, 8'h01), 32'd0);
    rx_frame(ID_TX_BASE + 11'd1, sdo_low(CMD_READ_ACK1, 16'h2000, 8'h02), 32'd0);
    repeat (5) tick();
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK1, 16'h2000, 8'h02), 32'h5555_AAAA);
  endtask

  // zero registers behave as one, node zero uses the bare base ids
  task automatic test_zero_regs();
    settle();
    set_regs(7'd0, 4'd0, 8'd0);
    start_xfer(1'b0, 16'h0001, 8'h80, 32'h1234_5678);
    tick();
    start_xfer(1'b1, 16'h8000, 8'h7F, 32'd0);
    rx_frame(rx_id(), sdo_low(CMD_READ_ACK4, 16'h8000, 8'h7E), 32'd0);
    start_xfer(1'b1, 16'h8000, 8'h7F, 32'd0);
    rx_frame(11'h580, sdo_low(CMD_READ_ACK4, 16'h8000, 8'h7F), 32'hCAFE_0000);
    start_xfer(1'b0, 16'h00FF, 8'h10, 32'h0F0F_0F0F);
    rx_frame(11'h580, sdo_low(CMD_WRITE_ACK, 16'h00FF, 8'h10), 32'd0);
  endtask

  task automatic test_top_regs();
    settle();
    set_regs(7'd127, 4'd15, 8'd255);
    start_xfer(1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    // aborts run the attempt counter out, the last one is dropped while idle
    repeat (16) rx_frame(rx_id(), sdo_low(8'h80, 16'hFFFF, 8'hFF), 32'd0);
    start_xfer(1'b1, 16'h7FFF, 8'h01, 32'd0);
    repeat (255) tick();
    rx_frame(11'h5FF, sdo_low(CMD_READ_ACK4, 16'h7FFF, 8'h01), 32'hFEDC_BA98);
    start_xfer(1'b0, 16'h0000, 8'h00, 32'h0000_0001);
    rx_frame(11'h5FF, sdo_low(CMD_WRITE_ACK, 16'h0000, 8'h00), 32'd0);
  endtask

  // receiver holds off while starts keep coming, so the input side must stall
  task automatic test_backpressure();
    settle();
    set_regs(7'd5, 4'd3, 8'd4);
    @(posedge clk);
    hold_req = 1'b1;
    calm = 1'b1;
    repeat (40) start_xfer(1'($urandom), 16'($urandom), 8'($urandom), $urandom);
    calm = 1'b0;
  endtask

  task automatic test_random_phase(input int n_beats, input bit quiet, input bit wide_tmo);
    int          first;
    int          steps;
    int          n;
    int          pick;
    int          tmo_eff;
    bit          rd;
    bit          done;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [7:0]  cmd;
    logic [10:0] fid;
    logic [31:0] lo;
    settle();
    set_regs(7'($urandom_range(0, 127)),
             ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4)),
             wide_tmo ? 8'($urandom_range(9, 40)) : 8'($urandom_range(0, 6)));
    calm = quiet;
    tmo_eff = (tmo_ticks_r == 8'd0) ? 1 : tmo_ticks_r;
    first = beats_sent;
    while (beats_sent - first < n_beats) begin
      if ($urandom_range(99) < 20) begin
        send_beat(func_t'($urandom_range(3)), 16'($urandom), 8'($urandom), $urandom,
                  11'($urandom), $urandom, $urandom);
      end else begin
        rd  = 1'($urandom);
        idx = 16'($urandom);
        sub = 8'($urandom);
        start_xfer(rd, idx, sub, $urandom);
        steps = $urandom_range(0, max_tries_r + 2);
        done = 1'b0;
        for (int s = 0; s < steps && !done; s++) begin
          pick = $urandom_range(99);
          if (pick < 25) begin
            n = $urandom_range(1) ? tmo_eff : $urandom_range(1, tmo_eff);
            repeat (n) tick();
          end else begin
            case ($urandom_range(3))
              0: cmd = CMD_READ_ACK4;
              1: cmd = CMD_READ_ACK3;
              2: cmd = CMD_READ_ACK2;
              default: cmd = CMD_READ_ACK1;
            endcase
            if (!rd) cmd = CMD_WRITE_ACK;
            fid = rx_id();
            lo  = sdo_low(cmd, idx, sub);
            if (pick < 60) begin
              done = 1'b1;
            end else begin
              case ($urandom_range(5))
                0: fid = fid ^ (11'd1 << $urandom_range(10));
                1: lo[7:0] = rd ? CMD_WRITE_ACK : CMD_READ_ACK4;
                2: lo[7:0] = 8'h80;
                3: lo[23:8] = lo[23:8] ^ (16'd1 << $urandom_range(15));
                4: lo[31:24] = lo[31:24] ^ (8'd1 << $urandom_range(7));
                default: lo[7:0] = 8'($urandom);
              endcase
            end
            rx_frame(fid, lo, $urandom);
          end
        end
      end
    end
    calm = 1'b0;
  endtask

  // receiver: random stalls, or a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 200;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      kind_seen[out_kind]++;
      if (sdo_events_q.size() == 0) begin
        $display("%0t: result beat with nothing pending, kind %0d", $time, out_kind);
        mismatches++;
      end else begin
        want = sdo_events_q.pop_front();
        if (out_kind != want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, out_kind);
          mismatches++;
        end
        if (out_tx_id != want.tx_id) begin
          $display("%0t: tx_id expected %h got %h", $time, want.tx_id, out_tx_id);
          mismatches++;
        end
        if (out_tx_low != want.tx_low) begin
          $display("%0t: tx_low expected %h got %h", $time, want.tx_low, out_tx_low);
          mismatches++;
        end
        if (out_tx_high != want.tx_high) begin
          $display("%0t: tx_high expected %h got %h", $time, want.tx_high, out_tx_high);
          mismatches++;
        end
        if (out_read_value != want.read_value) begin
          $display("%0t: read_value expected %h got %h", $time, want.read_value,
                   out_read_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_regs();
    test_top_regs();
    test_backpressure();
    for (int p = 0; p < 6; p++)
      test_random_phase(75, p == 2, p == 4);
    settle();
    repeat (10) @(negedge clk);
    if (sdo_events_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sdo_events_q.size());
      mismatches += sdo_events_q.size();
    end
    $display("%0d input beats over %0d register settings, %0d result beats", beats_sent,
             phases_run + 1, beats_seen);
    $display("  sends %0d, write done %0d, read done %0d, failed %0d", kind_seen[0],
             kind_seen[1], kind_seen[2], kind_seen[3]);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
